// ===== hdl/i2csrb_pkg.sv =====
// Shared types and constants for the I2C slave register bank.
package i2csrb_pkg;

  // Register bank geometry
  localparam int NUM_REGS  = 32;
  localparam int IDX_W     = 5;
  localparam int DATA_W    = 8;
  localparam logic [DATA_W-1:0] BANK_RESET_VAL = 8'hDE;

  // Configuration port geometry and register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_SLAVE_ADDR  = 2'd0;
  localparam logic [1:0] REG_BUS_WR_MASK = 2'd1;
  localparam logic [1:0] REG_READ_LIMIT  = 2'd2;
  localparam logic [5:0] READ_LIMIT_RESET = 6'd32;

  // Event codes of an input transaction
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_STOP   = 3'd1,
    MODE_SHIFT  = 3'd2,
    MODE_LREAD  = 3'd3,
    MODE_LWRITE = 3'd4
  } mode_t;

  // Bus action codes of a result transaction
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ACK         = 3'd1,
    ACT_DATA        = 3'd2,
    ACT_SAMPLE_ACK  = 3'd3,
    ACT_SAMPLE_BYTE = 3'd4,
    ACT_IDLE        = 3'd5
  } action_t;

  // Byte sequencer phases
  typedef enum logic [2:0] {
    PH_ADDR      = 3'd0,
    PH_SEND      = 3'd1,
    PH_REQ_REPLY = 3'd2,
    PH_CHK_REPLY = 3'd3,
    PH_REQ_IDX   = 3'd4,
    PH_GET_IDX   = 3'd5,
    PH_GET_VAL   = 3'd6,
    PH_REQ_VAL   = 3'd7
  } phase_t;

  // Configuration register contents
  typedef struct packed {
    logic [6:0]  slave_address;
    logic [31:0] bus_wr_mask;
    logic [5:0]  read_limit;
  } cfg_t;

  // Register bank write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } bank_wr_t;

endpackage

// ===== hdl/i2c_slave_register_bank_top.sv =====
// Top level of the I2C slave register bank.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   mode, rx_byte, reg_index, local_value
//   out_      output     out_valid/out_stall action, tx_byte, read_value, ok
//   config    input      psel/penable/pwrite slave_address, bus_wr_mask, read_limit
//
// One transaction per cycle while the result is not stalled; each passes the input
// register, then the result register. Sequencer state and the register bank are updated
// as a transaction moves from the input register to the result register.
// Synchronous reset loads the whole bank with 0xDE.
// A stalled result holds in the result register while one more transaction
// is taken into the input register.
module i2c_slave_register_bank_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_mode,
  input  logic [7:0]                          in_rx_byte,
  input  logic [7:0]                          in_reg_index,
  input  logic [7:0]                          in_local_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_action,
  output logic [7:0]                          out_tx_byte,
  output logic [7:0]                          out_read_value,
  output logic                                out_ok,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2csrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [i2csrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [i2csrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [2:0]                    s1_mode_r;
  logic [7:0]                    s1_rx_r;
  logic [7:0]                    s1_idx_r;
  logic [7:0]                    s1_val_r;
  logic                          s1_adv;
  logic                          in_take;
  logic                          go;
  logic                          out_valid_r, out_valid_nxt;
  logic [2:0]                    out_action_r;
  logic [7:0]                    out_tx_r;
  logic [7:0]                    out_rv_r;
  logic                          out_ok_r;
  i2csrb_pkg::cfg_t              cfg;
  i2csrb_pkg::bank_wr_t          wr;
  logic [i2csrb_pkg::IDX_W-1:0]  rd_addr;
  logic [i2csrb_pkg::DATA_W-1:0] rd_data;
  i2csrb_pkg::action_t           action;
  logic [7:0]                    tx_byte;
  logic [7:0]                    read_value;
  logic                          ok;

  // Advance when the result register is free or being emptied
  assign s1_adv   = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = go || (out_valid_r && out_stall);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_rx_r   <= in_rx_byte;
      s1_idx_r  <= in_reg_index;
      s1_val_r  <= in_local_value;
    end
  end

  i2csrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2csrb_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2csrb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .mode        (s1_mode_r),
    .rx_byte     (s1_rx_r),
    .reg_index   (s1_idx_r),
    .local_value (s1_val_r),
    .cfg         (cfg),
    .rd_data     (rd_data),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .action      (action),
    .tx_byte     (tx_byte),
    .read_value  (read_value),
    .ok          (ok)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_action_r <= action;
      out_tx_r     <= tx_byte;
      out_rv_r     <= read_value;
      out_ok_r     <= ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_tx_byte    = out_tx_r;
  assign out_read_value = out_rv_r;
  assign out_ok         = out_ok_r;

endmodule

// ===== hdl/i2csrb_cfg.sv =====
// APB-style configuration registers of the I2C slave register bank.
module i2csrb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2csrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [i2csrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [i2csrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  output i2csrb_pkg::cfg_t                    cfg
);

  logic [6:0]  slave_address_r;
  logic [31:0] bus_wr_mask_r;
  logic [5:0]  read_limit_r;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= '0;
      bus_wr_mask_r   <= '0;
      read_limit_r    <= i2csrb_pkg::READ_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        i2csrb_pkg::REG_SLAVE_ADDR:  slave_address_r <= pwdata[6:0];
        i2csrb_pkg::REG_BUS_WR_MASK: bus_wr_mask_r   <= pwdata;
        i2csrb_pkg::REG_READ_LIMIT:  read_limit_r    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      i2csrb_pkg::REG_SLAVE_ADDR:  prdata = {25'd0, slave_address_r};
      i2csrb_pkg::REG_BUS_WR_MASK: prdata = bus_wr_mask_r;
      i2csrb_pkg::REG_READ_LIMIT:  prdata = {26'd0, read_limit_r};
      default:                     prdata = '0;
    endcase
  end

  assign cfg.slave_address = slave_address_r;
  assign cfg.bus_wr_mask   = bus_wr_mask_r;
  assign cfg.read_limit    = read_limit_r;

endmodule

// ===== hdl/i2csrb_bank.sv =====
// Register file of the I2C slave: one write port, one read port.
module i2csrb_bank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  i2csrb_pkg::bank_wr_t                wr,
  input  logic [i2csrb_pkg::IDX_W-1:0]        rd_addr,
  output logic [i2csrb_pkg::DATA_W-1:0]       rd_data
);

  logic [i2csrb_pkg::DATA_W-1:0] bank_r [i2csrb_pkg::NUM_REGS];

  // Load the reset pattern, then take one write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < i2csrb_pkg::NUM_REGS; i++) begin
        bank_r[i] <= i2csrb_pkg::BANK_RESET_VAL;
      end
    end else if (wr.en) begin
      bank_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = bank_r[rd_addr];

endmodule

// ===== hdl/i2csrb_seq.sv =====
// Byte-level bus sequencer and local access decode of the I2C slave.
module i2csrb_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [2:0]                          mode,
  input  logic [7:0]                          rx_byte,
  input  logic [7:0]                          reg_index,
  input  logic [7:0]                          local_value,
  input  i2csrb_pkg::cfg_t                    cfg,
  input  logic [i2csrb_pkg::DATA_W-1:0]       rd_data,
  output logic [i2csrb_pkg::IDX_W-1:0]        rd_addr,
  output i2csrb_pkg::bank_wr_t                wr,
  output i2csrb_pkg::action_t                 action,
  output logic [7:0]                          tx_byte,
  output logic [7:0]                          read_value,
  output logic                                ok
);

  i2csrb_pkg::phase_t            phase_r, phase_nxt;
  logic                          active_r, active_nxt;
  logic [i2csrb_pkg::IDX_W-1:0]  cursor_r, cursor_nxt;
  i2csrb_pkg::mode_t             mode_e;
  logic [i2csrb_pkg::IDX_W-1:0]  cursor_inc;
  logic [i2csrb_pkg::IDX_W-1:0]  cursor_adv;
  logic                          addr_hit;
  logic                          rx_in_range;
  logic                          idx_in_range;
  logic                          rd_allowed;

  assign mode_e       = i2csrb_pkg::mode_t'(mode);
  assign addr_hit     = (rx_byte == 8'd0) || (rx_byte[7:1] == cfg.slave_address);
  assign rx_in_range  = {1'b0, rx_byte} < 9'(i2csrb_pkg::NUM_REGS);
  assign idx_in_range = {1'b0, reg_index} < 9'(i2csrb_pkg::NUM_REGS);
  assign rd_allowed   = idx_in_range && ({1'b0, reg_index} < {3'd0, cfg.read_limit});

  // Step the read cursor, wrapping at the bank size
  assign cursor_inc = cursor_r + 1'b1;
  assign cursor_adv = (6'(cursor_inc) >= 6'(i2csrb_pkg::NUM_REGS)) ? '0 : cursor_inc;

  // Local reads use the supplied index, bus reads the cursor
  assign rd_addr = (mode_e == i2csrb_pkg::MODE_LREAD) ? reg_index[i2csrb_pkg::IDX_W-1:0]
                                                      : cursor_r;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    cursor_nxt = cursor_r;
    if (go) begin
      unique case (mode_e)
        i2csrb_pkg::MODE_START: begin
          phase_nxt  = i2csrb_pkg::PH_ADDR;
          active_nxt = 1'b1;
        end
        i2csrb_pkg::MODE_STOP: begin
          active_nxt = 1'b0;
        end
        i2csrb_pkg::MODE_SHIFT: begin
          if (active_r) begin
            unique case (phase_r)
              i2csrb_pkg::PH_ADDR: begin
                if (addr_hit) begin
                  phase_nxt = rx_byte[0] ? i2csrb_pkg::PH_SEND : i2csrb_pkg::PH_REQ_IDX;
                end else begin
                  active_nxt = 1'b0;
                end
              end
              i2csrb_pkg::PH_CHK_REPLY: begin
                if (rx_byte != 8'd0) begin
                  cursor_nxt = '0;
                  active_nxt = 1'b0;
                end else begin
                  cursor_nxt = cursor_adv;
                  phase_nxt  = i2csrb_pkg::PH_REQ_REPLY;
                end
              end
              i2csrb_pkg::PH_SEND: begin
                cursor_nxt = cursor_adv;
                phase_nxt  = i2csrb_pkg::PH_REQ_REPLY;
              end
              i2csrb_pkg::PH_REQ_REPLY: phase_nxt = i2csrb_pkg::PH_CHK_REPLY;
              i2csrb_pkg::PH_REQ_IDX:   phase_nxt = i2csrb_pkg::PH_GET_IDX;
              i2csrb_pkg::PH_GET_IDX: begin
                if (rx_in_range) begin
                  cursor_nxt = rx_byte[i2csrb_pkg::IDX_W-1:0];
                  phase_nxt  = i2csrb_pkg::PH_REQ_VAL;
                end else begin
                  active_nxt = 1'b0;
                end
              end
              i2csrb_pkg::PH_REQ_VAL:   phase_nxt = i2csrb_pkg::PH_GET_VAL;
              i2csrb_pkg::PH_GET_VAL:   phase_nxt = i2csrb_pkg::PH_REQ_IDX;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs and register bank writes
  always_comb begin
    action     = i2csrb_pkg::ACT_NONE;
    tx_byte    = '0;
    read_value = '0;
    ok         = 1'b0;
    wr.en      = 1'b0;
    wr.addr    = cursor_r;
    wr.data    = rx_byte;
    unique case (mode_e)
      i2csrb_pkg::MODE_START: action = i2csrb_pkg::ACT_SAMPLE_BYTE;
      i2csrb_pkg::MODE_STOP:  action = i2csrb_pkg::ACT_IDLE;
      i2csrb_pkg::MODE_SHIFT: begin
        if (active_r) begin
          unique case (phase_r)
            i2csrb_pkg::PH_ADDR: begin
              action = addr_hit ? i2csrb_pkg::ACT_ACK : i2csrb_pkg::ACT_IDLE;
            end
            i2csrb_pkg::PH_CHK_REPLY: begin
              if (rx_byte != 8'd0) begin
                action = i2csrb_pkg::ACT_IDLE;
              end else begin
                action  = i2csrb_pkg::ACT_DATA;
                tx_byte = rd_data;
              end
            end
            i2csrb_pkg::PH_SEND: begin
              action  = i2csrb_pkg::ACT_DATA;
              tx_byte = rd_data;
            end
            i2csrb_pkg::PH_REQ_REPLY: action = i2csrb_pkg::ACT_SAMPLE_ACK;
            i2csrb_pkg::PH_REQ_IDX:   action = i2csrb_pkg::ACT_SAMPLE_BYTE;
            i2csrb_pkg::PH_GET_IDX: begin
              action = rx_in_range ? i2csrb_pkg::ACT_ACK : i2csrb_pkg::ACT_IDLE;
            end
            i2csrb_pkg::PH_REQ_VAL:   action = i2csrb_pkg::ACT_SAMPLE_BYTE;
            i2csrb_pkg::PH_GET_VAL: begin
              action = i2csrb_pkg::ACT_ACK;
              wr.en  = go && cfg.bus_wr_mask[cursor_r];
            end
            default: ;
          endcase
        end
      end
      i2csrb_pkg::MODE_LREAD: begin
        if (rd_allowed) begin
          read_value = rd_data;
          ok         = 1'b1;
        end
      end
      i2csrb_pkg::MODE_LWRITE: begin
        if (idx_in_range) begin
          ok      = 1'b1;
          wr.en   = go;
          wr.addr = reg_index[i2csrb_pkg::IDX_W-1:0];
          wr.data = local_value;
        end
      end
      default: ;
    endcase
  end

  // Hold sequencer state between events
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2csrb_pkg::PH_ADDR;
      active_r <= 1'b0;
      cursor_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      cursor_r <= cursor_nxt;
    end
  end

endmodule

// ===== hdl/i2csrb_checker.sv =====
// Port-level checks for the I2C slave register bank, bound to the top level.
module i2csrb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_action,
  input logic [7:0] out_tx_byte,
  input logic [7:0] out_read_value,
  input logic       out_ok
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A transmit byte only comes with a drive data action
  a_tx_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != i2csrb_pkg::ACT_DATA) |-> out_tx_byte == 8'd0)
    else $error("tx byte without data action");

  // Local access results carry no bus action
  a_ok_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_action == i2csrb_pkg::ACT_NONE)
    else $error("local access with bus action");

  // A read value implies an in-range local access
  a_rv_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != 8'd0) |-> out_ok)
    else $error("read value without ok");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) && $stable(out_tx_byte)
      && $stable(out_read_value) && $stable(out_ok))
    else $error("stalled result changed");

endmodule

bind i2c_slave_register_bank_top i2csrb_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_action     (out_action),
  .out_tx_byte    (out_tx_byte),
  .out_read_value (out_read_value),
  .out_ok         (out_ok)
);
